/* src/crtc_pkg.sv */
// Shared types, register codes and small constant-divide helpers for the
// cartridge real-time clock. No dependencies.
package crtc_pkg;

    // Field limits of the time-of-day count.
    localparam int SecsPerMin  = 60;
    localparam int MinsPerHour = 60;
    localparam int HoursPerDay = 24;

    // Item actions.
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_LATCH = 2'd1,
        ACT_READ  = 2'd2,
        ACT_WRITE = 2'd3
    } t_action;

    // Register select codes.
    localparam logic [2:0] REG_SEC     = 3'd0;
    localparam logic [2:0] REG_MIN     = 3'd1;
    localparam logic [2:0] REG_HOUR    = 3'd2;
    localparam logic [2:0] REG_DAY_LO  = 3'd3;
    localparam logic [2:0] REG_CONTROL = 3'd4;

    // Control byte layout and the value returned for an unknown register.
    localparam int         CTRL_DAY8_BIT = 0;
    localparam int         CTRL_HALT_BIT = 6;
    localparam logic [7:0] RDATA_INVALID = 8'hFF;

    // Live or latched count, held as separate time fields.
    typedef struct packed {
        logic [8:0] day;
        logic [4:0] hour;
        logic [5:0] min;
        logic [5:0] sec;
    } t_time;

    // Command from the execute stage to the counter.
    typedef struct packed {
        logic       tick;
        logic       write;
        logic [2:0] sel;
        logic [7:0] wdata;
    } t_cmd;

    // Quotient of an 8-bit value by 60, from independent threshold compares.
    function automatic logic [2:0] div60(input logic [7:0] v);
        logic [2:0] q;
        q = '0;
        for (int k = 1; k <= 4; k++) begin
            if (v >= 8'(k * SecsPerMin)) q = q + 3'd1;
        end
        return q;
    endfunction

    // Quotient of an 8-bit value by 24, from independent threshold compares.
    function automatic logic [3:0] div24(input logic [7:0] v);
        logic [3:0] q;
        q = '0;
        for (int k = 1; k <= 10; k++) begin
            if (v >= 8'(k * HoursPerDay)) q = q + 4'd1;
        end
        return q;
    endfunction

endpackage

/* src/crtc_counter.sv */
// Live time count and halt flag of the real-time clock: second ticks and
// field writes with carry into the higher fields. Depends on crtc_pkg.
module crtc_counter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  crtc_pkg::t_cmd   i_cmd,
    output crtc_pkg::t_time  o_time,
    output logic             o_halted
);

    crtc_pkg::t_time r_time, n_time;
    logic            r_halted, n_halted;

    // Quotients and remainders of the written value.
    logic [2:0] q60;
    logic [3:0] q24;
    logic [7:0] rem60, rem24;
    logic [6:0] min_sum;
    logic [5:0] hour_sum;
    logic       min_carry, hour_carry;

    always_comb begin
        q60   = crtc_pkg::div60(i_cmd.wdata);
        q24   = crtc_pkg::div24(i_cmd.wdata);
        rem60 = i_cmd.wdata - 8'(8'(q60) * 8'(crtc_pkg::SecsPerMin));
        rem24 = i_cmd.wdata - 8'(8'(q24) * 8'(crtc_pkg::HoursPerDay));
    end

    // Next count: a tick advances by one second unless halted; a write replaces one
    // field and lets any excess spill into the fields above, the day count wrapping at 512.
    always_comb begin
        n_time     = r_time;
        n_halted   = r_halted;
        min_sum    = '0;
        hour_sum   = '0;
        min_carry  = 1'b0;
        hour_carry = 1'b0;
        if (i_cmd.tick && !r_halted) begin
            if (r_time.sec == 6'(crtc_pkg::SecsPerMin - 1)) begin
                n_time.sec = '0;
                if (r_time.min == 6'(crtc_pkg::MinsPerHour - 1)) begin
                    n_time.min = '0;
                    if (r_time.hour == 5'(crtc_pkg::HoursPerDay - 1)) begin
                        n_time.hour = '0;
                        n_time.day  = r_time.day + 9'd1;
                    end else begin
                        n_time.hour = r_time.hour + 5'd1;
                    end
                end else begin
                    n_time.min = r_time.min + 6'd1;
                end
            end else begin
                n_time.sec = r_time.sec + 6'd1;
            end
        end else if (i_cmd.write) begin
            unique case (i_cmd.sel)
                crtc_pkg::REG_SEC: begin
                    n_time.sec  = rem60[5:0];
                    min_sum     = 7'(r_time.min) + 7'(q60);
                    min_carry   = min_sum >= 7'(crtc_pkg::MinsPerHour);
                    n_time.min  = min_carry ? 6'(min_sum - 7'(crtc_pkg::MinsPerHour))
                                            : min_sum[5:0];
                    hour_sum    = 6'(r_time.hour) + 6'(min_carry);
                    hour_carry  = hour_sum >= 6'(crtc_pkg::HoursPerDay);
                    n_time.hour = hour_carry ? 5'(hour_sum - 6'(crtc_pkg::HoursPerDay))
                                             : hour_sum[4:0];
                    n_time.day  = r_time.day + 9'(hour_carry);
                end
                crtc_pkg::REG_MIN: begin
                    n_time.min  = rem60[5:0];
                    hour_sum    = 6'(r_time.hour) + 6'(q60);
                    hour_carry  = hour_sum >= 6'(crtc_pkg::HoursPerDay);
                    n_time.hour = hour_carry ? 5'(hour_sum - 6'(crtc_pkg::HoursPerDay))
                                             : hour_sum[4:0];
                    n_time.day  = r_time.day + 9'(hour_carry);
                end
                crtc_pkg::REG_HOUR: begin
                    n_time.hour = rem24[4:0];
                    n_time.day  = r_time.day + 9'(q24);
                end
                crtc_pkg::REG_DAY_LO: begin
                    n_time.day[7:0] = i_cmd.wdata;
                end
                crtc_pkg::REG_CONTROL: begin
                    n_time.day[8] = i_cmd.wdata[crtc_pkg::CTRL_DAY8_BIT];
                    n_halted      = i_cmd.wdata[crtc_pkg::CTRL_HALT_BIT];
                end
                default: begin
                    n_time = r_time;
                end
            endcase
        end
    end

    // Count and halt flag registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time   <= '0;
            r_halted <= 1'b0;
        end else begin
            r_time   <= n_time;
            r_halted <= n_halted;
        end
    end

    assign o_time   = r_time;
    assign o_halted = r_halted;

endmodule

/* src/cartridge_rtc_registers.sv */
// Top level of the cartridge real-time clock register block: input register,
// latched copy, read select and result register. Depends on crtc_pkg, crtc_counter.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+--------------------------------
//   in      | to block  | i_in_valid / o_in_stall    | i_action, i_reg_select, i_wdata
//   out     | from block| o_out_valid / i_out_stall  | o_rdata
//
// One item is taken every cycle unless a stall holds it. An item is held in the input
// register and executed there; a read result then goes through the result register
// to the output. Only a read meeting a full, stalled result register waits.
// Synchronous active-low reset clears the count, latched copy and halt flag.
module cartridge_rtc_registers (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_action,
    input  logic [2:0] i_reg_select,
    input  logic [7:0] i_wdata,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_rdata
);

    logic                r_in_valid;
    crtc_pkg::t_action   r_action;
    logic [2:0]          r_sel;
    logic [7:0]          r_wdata;
    crtc_pkg::t_time     r_latched;
    logic                r_out_valid;
    logic [7:0]          r_rdata;
    logic [7:0]          n_rdata;

    crtc_pkg::t_cmd      cmd;
    crtc_pkg::t_time     live_time;
    logic                halted;
    logic                is_read;
    logic                fire;

    // The held item executes unless it is a read and the result slot is blocked.
    assign is_read    = r_action == crtc_pkg::ACT_READ;
    assign fire       = r_in_valid && !(is_read && r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_action <= crtc_pkg::t_action'(i_action);
            r_sel    <= i_reg_select;
            r_wdata  <= i_wdata;
        end
    end

    // Command to the live counter.
    always_comb begin
        cmd.tick  = fire && (r_action == crtc_pkg::ACT_TICK);
        cmd.write = fire && (r_action == crtc_pkg::ACT_WRITE);
        cmd.sel   = r_sel;
        cmd.wdata = r_wdata;
    end

    crtc_counter u_counter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_time   (live_time),
        .o_halted (halted)
    );

    // Latched copy of the live count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched <= '0;
        end else if (fire && (r_action == crtc_pkg::ACT_LATCH) && r_wdata[0]) begin
            r_latched <= live_time;
        end
    end

    // Read select from the latched count; the halt bit is the current flag.
    always_comb begin
        n_rdata = crtc_pkg::RDATA_INVALID;
        unique case (r_sel)
            crtc_pkg::REG_SEC:     n_rdata = 8'(r_latched.sec);
            crtc_pkg::REG_MIN:     n_rdata = 8'(r_latched.min);
            crtc_pkg::REG_HOUR:    n_rdata = 8'(r_latched.hour);
            crtc_pkg::REG_DAY_LO:  n_rdata = r_latched.day[7:0];
            crtc_pkg::REG_CONTROL: begin
                n_rdata = '0;
                n_rdata[crtc_pkg::CTRL_DAY8_BIT] = r_latched.day[8];
                n_rdata[crtc_pkg::CTRL_HALT_BIT] = halted;
            end
            default:               n_rdata = crtc_pkg::RDATA_INVALID;
        endcase
    end

    // Result register; it drains on a transfer and reloads on a read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && is_read) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && is_read) begin
            r_rdata <= n_rdata;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rdata     = r_rdata;

endmodule
